// ----- rtl/core/aho_corasick_matcher_macros.svh -----
// Assertion macros shared by the matcher RTL.
`ifndef AHO_CORASICK_MATCHER_MACROS_SVH
`define AHO_CORASICK_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define ACM_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("matcher assertion failed");
`define ACM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("matcher assertion failed");
`else
`define ACM_ASSERT(label, prop)
`define ACM_ASSERT_IMP(label, ante, cons)
`endif
`endif

// ----- rtl/core/acm_pkg.sv -----
// Shared constants, codes and state type of the multi-pattern matcher.
package acm_pkg;

    localparam int MAX_NODES_DEF    = 256;
    localparam int MAX_PATTERNS_DEF = 16;
    localparam int ALPHABET         = 26;
    localparam int POS_BITS         = 32;
    localparam int SYM_W            = 5;
    localparam int LETTER_W         = $clog2(ALPHABET);

    typedef enum logic [1:0] {
        FN_PAT   = 2'd0,
        FN_BUILD = 2'd1,
        FN_TEXT  = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REJ,
        ST_P_ROW,
        ST_P_BM,
        ST_B_ROOT,
        ST_B_ENQ0,
        ST_B_DEQ,
        ST_B_QRD,
        ST_B_ROWU,
        ST_B_ROWF,
        ST_B_SCAN,
        ST_B_BMF,
        ST_B_BMV,
        ST_B_WRROW,
        ST_T_STEP,
        ST_T_BITS,
        ST_T_EMIT
    } t_state;

endpackage

// ----- rtl/core/acm_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
module acm_ram
    import acm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

// ----- rtl/core/aho_corasick_matcher.sv -----
// The block takes one item at a time. A text letter within the alphabet takes a goto step and
// fetches its match set, then gives its matches one per cycle while the output is not stalled.
// A pattern letter follows or adds a child edge; a build works through the nodes in queue order.
// The row-wide transition memory has one row per node and one port each way.
// Reset is synchronous, active low; after it a clearing pass zeroes the transition and
// bitmap memories, during which no item is taken.
`include "aho_corasick_matcher_macros.svh"
module aho_corasick_matcher
    import acm_pkg::*;
#(
    parameter int MAX_NODES    = MAX_NODES_DEF,
    parameter int MAX_PATTERNS = MAX_PATTERNS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_func,
    input  logic [SYM_W-1:0] i_symbol,
    input  logic             i_last_of_pattern,
    input  logic             i_first_of_text,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_status,
    output logic [3:0]       o_pattern_id,
    output logic [31:0]      o_start_position,
    output logic             o_last
);

    localparam int NB = $clog2(MAX_NODES);
    localparam int RW = ALPHABET * NB;
    localparam int PB = $clog2(MAX_PATTERNS + 1);
    localparam int IB = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int MP = MAX_PATTERNS;

    // Control and datapath registers.
    t_state             r_state, n_state;
    logic [NB-1:0]      r_clr, n_clr;
    logic [NB:0]        r_node_count, n_node_count;
    logic [PB-1:0]      r_pat_count, n_pat_count;
    logic [NB-1:0]      r_cursor, n_cursor;
    logic               r_built, n_built;
    logic [NB-1:0]      r_scan, n_scan;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [NB-1:0]      r_plen [MP];
    logic [NB-1:0]      n_plen [MP];
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic               r_final, n_final;
    logic [NB-1:0]      r_head, n_head, r_tail, n_tail;
    logic [NB-1:0]      r_u, n_u, r_f, n_f, r_v, n_v;
    logic [RW-1:0]      r_row_u, n_row_u, r_row_f, n_row_f;
    logic [LETTER_W-1:0] r_c, n_c;
    logic [MP-1:0]      r_bmf, n_bmf, r_bits, n_bits;
    logic               r_ovalid, n_ovalid;
    logic               r_status, n_status;
    logic [3:0]         r_id, n_id;
    logic [31:0]        r_start, n_start;
    logic               r_last, n_last;

    // Memory ports.
    logic               tt_we;
    logic [NB-1:0]      tt_waddr, tt_raddr;
    logic [RW-1:0]      tt_wdata, tt_rdata;
    logic               bm_we;
    logic [NB-1:0]      bm_waddr, bm_raddr;
    logic [MP-1:0]      bm_wdata, bm_rdata;
    logic               q_we;
    logic [NB-1:0]      q_waddr, q_raddr;
    logic [2*NB-1:0]    q_wdata, q_rdata;

    acm_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_trans (
        .i_clk(i_clk), .i_we(tt_we), .i_waddr(tt_waddr), .i_wdata(tt_wdata),
        .i_raddr(tt_raddr), .o_rdata(tt_rdata)
    );
    acm_ram #(.WIDTH(MP), .DEPTH(MAX_NODES)) u_bitmap (
        .i_clk(i_clk), .i_we(bm_we), .i_waddr(bm_waddr), .i_wdata(bm_wdata),
        .i_raddr(bm_raddr), .o_rdata(bm_rdata)
    );
    acm_ram #(.WIDTH(2 * NB), .DEPTH(MAX_NODES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    // Shared conditions.
    logic               in_acc, out_free, in_sym_bad, pat_bad, node_full, c_end, q_empty;
    logic [SYM_W-1:0]   sym_c;
    logic [NB-1:0]      child, scan_v, scan_fv, in_row;
    logic [MP-1:0]      bits_rem;
    logic [IB-1:0]      low_id;

    assign o_ready    = (r_state == ST_IDLE);
    assign in_acc     = i_valid && o_ready;
    assign out_free   = !r_ovalid || i_ready;
    assign in_sym_bad = (i_symbol >= SYM_W'(ALPHABET));
    assign pat_bad    = r_built || (r_pat_count == PB'(MP)) || in_sym_bad;
    assign node_full  = (r_node_count == (NB + 1)'(MAX_NODES));
    assign sym_c      = (r_sym < SYM_W'(ALPHABET)) ? r_sym : '0;
    assign child      = tt_rdata[sym_c*NB +: NB];
    assign scan_v     = r_row_u[r_c*NB +: NB];
    assign scan_fv    = r_row_f[r_c*NB +: NB];
    assign c_end      = (r_c == LETTER_W'(ALPHABET - 1));
    assign q_empty    = (r_head == r_tail);
    assign bits_rem   = r_bits & (r_bits - MP'(1));
    assign in_row     = i_first_of_text ? '0 : r_scan;

    // Lowest pending pattern id.
    always_comb begin
        low_id = '0;
        for (int k = MP - 1; k >= 0; k--) begin
            if (r_bits[k]) begin
                low_id = IB'(k);
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == NB'(MAX_NODES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    case (t_func'(i_func))
                        FN_PAT:   n_state = pat_bad ? ST_REJ : ST_P_ROW;
                        FN_BUILD: n_state = r_built ? ST_IDLE : ST_B_ROOT;
                        FN_TEXT: begin
                            if (r_built && !in_sym_bad) n_state = ST_T_STEP;
                        end
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_REJ:     if (out_free) n_state = ST_IDLE;
            ST_P_ROW: begin
                if (child == '0 && node_full) n_state = ST_REJ;
                else if (r_final)             n_state = ST_P_BM;
                else                          n_state = ST_IDLE;
            end
            ST_P_BM:    n_state = ST_IDLE;
            ST_B_ROOT:  n_state = ST_B_ENQ0;
            ST_B_ENQ0:  if (c_end) n_state = ST_B_DEQ;
            ST_B_DEQ:   n_state = q_empty ? ST_IDLE : ST_B_QRD;
            ST_B_QRD:   n_state = ST_B_ROWU;
            ST_B_ROWU:  n_state = ST_B_ROWF;
            ST_B_ROWF:  n_state = ST_B_SCAN;
            ST_B_SCAN: begin
                if (scan_v != '0) n_state = ST_B_BMF;
                else if (c_end)   n_state = ST_B_WRROW;
            end
            ST_B_BMF:   n_state = ST_B_BMV;
            ST_B_BMV:   n_state = c_end ? ST_B_WRROW : ST_B_SCAN;
            ST_B_WRROW: n_state = ST_B_DEQ;
            ST_T_STEP:  n_state = ST_T_BITS;
            ST_T_BITS:  n_state = (bm_rdata == '0) ? ST_IDLE : ST_T_EMIT;
            ST_T_EMIT: begin
                if (out_free && bits_rem == '0) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and result register.
    always_comb begin
        n_clr = r_clr;           n_node_count = r_node_count; n_pat_count = r_pat_count;
        n_cursor = r_cursor;     n_built = r_built;           n_scan = r_scan;
        n_pos = r_pos;           n_plen = r_plen;             n_sym = r_sym;
        n_final = r_final;       n_head = r_head;             n_tail = r_tail;
        n_u = r_u;               n_f = r_f;                   n_v = r_v;
        n_row_u = r_row_u;       n_row_f = r_row_f;           n_c = r_c;
        n_bmf = r_bmf;           n_bits = r_bits;
        n_ovalid = r_ovalid && !i_ready;
        n_status = r_status;     n_id = r_id;                 n_start = r_start;
        n_last = r_last;
        tt_we = 1'b0; tt_waddr = '0; tt_wdata = tt_rdata; tt_raddr = '0;
        bm_we = 1'b0; bm_waddr = '0; bm_wdata = '0;       bm_raddr = '0;
        q_we  = 1'b0; q_waddr  = r_tail; q_wdata = '0;    q_raddr = r_head;
        case (r_state)
            // Zero one row of both memories per cycle.
            ST_CLEAR: begin
                tt_we = 1'b1; tt_waddr = r_clr; tt_wdata = '0;
                bm_we = 1'b1; bm_waddr = r_clr; bm_wdata = '0;
                n_clr = r_clr + NB'(1);
            end
            // Take an item and start its first memory read.
            ST_IDLE: begin
                if (in_acc) begin
                    n_sym   = i_symbol;
                    n_final = i_last_of_pattern;
                    case (t_func'(i_func))
                        FN_PAT: begin
                            if (pat_bad) n_cursor = '0;
                            tt_raddr = r_cursor;
                        end
                        FN_BUILD: begin
                            n_c = '0; n_head = '0; n_tail = '0;
                        end
                        FN_TEXT: begin
                            if (r_built) begin
                                tt_raddr = in_row;
                                if (in_sym_bad) begin
                                    n_scan = '0;
                                    n_pos  = (i_first_of_text ? '0 : r_pos) + POS_BITS'(1);
                                end else if (i_first_of_text) begin
                                    n_pos = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Rejection result.
            ST_REJ: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_status = 1'b1; n_id = '0; n_start = '0; n_last = 1'b1;
                end
            end
            // Follow or add the child edge of the insert cursor.
            ST_P_ROW: begin
                if (child == '0 && node_full) begin
                    n_cursor = '0;
                end else begin
                    if (child == '0) begin
                        tt_we = 1'b1; tt_waddr = r_cursor;
                        tt_wdata[sym_c*NB +: NB] = r_node_count[NB-1:0];
                        n_node_count = r_node_count + (NB + 1)'(1);
                        n_v = r_node_count[NB-1:0];
                    end else begin
                        n_v = child;
                    end
                    n_plen[r_pat_count[IB-1:0]] = (r_cursor == '0) ? NB'(1)
                        : r_plen[r_pat_count[IB-1:0]] + NB'(1);
                    n_cursor = r_final ? '0 : ((child == '0) ? r_node_count[NB-1:0] : child);
                    bm_raddr = (child == '0) ? r_node_count[NB-1:0] : child;
                end
            end
            // Set the new pattern's bit in its final node.
            ST_P_BM: begin
                bm_we = 1'b1; bm_waddr = r_v;
                bm_wdata = bm_rdata | (MP'(1) << r_pat_count[IB-1:0]);
                n_pat_count = r_pat_count + PB'(1);
            end
            ST_B_ROOT: begin
                n_row_u = tt_rdata;
            end
            // Queue each child of the root with the root as its fail node.
            ST_B_ENQ0: begin
                if (scan_v != '0) begin
                    q_we = 1'b1; q_wdata = {scan_v, NB'(0)};
                    n_tail = r_tail + NB'(1);
                end
                n_c = r_c + LETTER_W'(1);
            end
            // Pop the next node, or finish the build.
            ST_B_DEQ: begin
                if (q_empty) begin
                    n_built = 1'b1; n_cursor = '0; n_scan = '0; n_pos = '0;
                end else begin
                    n_head = r_head + NB'(1);
                end
            end
            ST_B_QRD: begin
                n_u = q_rdata[2*NB-1:NB]; n_f = q_rdata[NB-1:0];
                tt_raddr = q_rdata[2*NB-1:NB];
            end
            ST_B_ROWU: begin
                n_row_u = tt_rdata; tt_raddr = r_f;
            end
            ST_B_ROWF: begin
                n_row_f = tt_rdata; n_c = '0;
            end
            // One letter of the popped row per pass.
            ST_B_SCAN: begin
                if (scan_v != '0) begin
                    q_we = 1'b1; q_wdata = {scan_v, scan_fv};
                    n_tail = r_tail + NB'(1);
                    n_v = scan_v;
                    bm_raddr = scan_fv;
                end else begin
                    n_row_u[r_c*NB +: NB] = scan_fv;
                    if (!c_end) n_c = r_c + LETTER_W'(1);
                end
            end
            ST_B_BMF: begin
                n_bmf = bm_rdata; bm_raddr = r_v;
            end
            // Fold the fail node's match set into the child.
            ST_B_BMV: begin
                bm_we = 1'b1; bm_waddr = r_v; bm_wdata = bm_rdata | r_bmf;
                if (!c_end) n_c = r_c + LETTER_W'(1);
            end
            ST_B_WRROW: begin
                tt_we = 1'b1; tt_waddr = r_u; tt_wdata = r_row_u;
            end
            // One goto step, then fetch the match set.
            ST_T_STEP: begin
                n_scan = child; bm_raddr = child;
            end
            ST_T_BITS: begin
                n_bits = bm_rdata;
                if (bm_rdata == '0) n_pos = r_pos + POS_BITS'(1);
            end
            // Report matches in ascending id order.
            ST_T_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_status = 1'b0; n_id = 4'(low_id);
                    n_start  = 32'(r_pos + POS_BITS'(1) - POS_BITS'(r_plen[low_id]));
                    n_last   = (bits_rem == '0);
                    n_bits   = bits_rem;
                    if (bits_rem == '0) n_pos = r_pos + POS_BITS'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;   r_clr <= '0;     r_node_count <= (NB + 1)'(1);
            r_pat_count <= '0;     r_cursor <= '0;  r_built <= 1'b0;
            r_scan <= '0;          r_pos <= '0;     r_head <= '0;
            r_tail <= '0;          r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;    r_clr <= n_clr;  r_node_count <= n_node_count;
            r_pat_count <= n_pat_count; r_cursor <= n_cursor; r_built <= n_built;
            r_scan <= n_scan;      r_pos <= n_pos;  r_head <= n_head;
            r_tail <= n_tail;      r_ovalid <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_plen <= n_plen;   r_sym <= n_sym;     r_final <= n_final;
        r_u <= n_u;         r_f <= n_f;         r_v <= n_v;
        r_row_u <= n_row_u; r_row_f <= n_row_f; r_c <= n_c;
        r_bmf <= n_bmf;     r_bits <= n_bits;   r_status <= n_status;
        r_id <= n_id;       r_start <= n_start; r_last <= n_last;
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_status;
    assign o_pattern_id     = r_id;
    assign o_start_position = r_start;
    assign o_last           = r_last;

    `ACM_ASSERT(a_node_count_range, (r_node_count != '0) && (r_node_count <= (NB + 1)'(MAX_NODES)))
    `ACM_ASSERT(a_queue_order, r_head <= r_tail)
    `ACM_ASSERT_IMP(a_emit_has_bits, r_state == ST_T_EMIT, r_bits != '0)
    `ACM_ASSERT_IMP(a_build_resets_scan, $rose(r_built), (r_scan == '0) && (r_pos == '0) && (r_cursor == '0))

endmodule

// ----- bench/acm_match_checker.sv -----
// Watches the matcher's item channels, predicts its match reports and compares them.
module acm_match_checker
    import acm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [1:0]       i_func,
    input  logic [SYM_W-1:0] i_symbol,
    input  logic             i_last_of_pattern,
    input  logic             i_first_of_text,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic             i_status,
    input  logic [3:0]       i_pattern_id,
    input  logic [31:0]      i_start_position,
    input  logic             i_last,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_report_count
);

    localparam int NODES = MAX_NODES_DEF;
    localparam int PATS  = MAX_PATTERNS_DEF;

    typedef struct packed {
        logic        status;
        logic [3:0]  id;
        logic [31:0] start;
        logic        last;
    } t_report;

    // Shadow copy of the automaton.
    logic [7:0]       goto_tab [NODES*ALPHABET];
    logic [7:0]       fail_of  [NODES];
    logic [15:0]      hits_of  [NODES];
    logic [7:0]       pat_len  [PATS];
    int               n_nodes;
    int               n_pats;
    int               cursor;
    logic             is_built;
    int               scan_at;
    logic [31:0]      text_pos;
    t_report          expected_reports [$];

    assign o_pending = expected_reports.size();

    task automatic report_mismatch(input string what, input t_report got, input t_report want);
        $display("mismatch %s: got st=%0d id=%0d pos=%0d last=%0d, want st=%0d id=%0d pos=%0d last=%0d",
            what, got.status, got.id, got.start, got.last,
            want.status, want.id, want.start, want.last);
        o_fail_count++;
    endtask

    task automatic push_reject();
        t_report r;
        r = '{status: 1'b1, id: 4'd0, start: 32'd0, last: 1'b1};
        expected_reports.push_back(r);
        cursor = 0;
    endtask

    task automatic add_letter(input int sym, input logic fin);
        int slot;
        int child;
        if (is_built || n_pats >= PATS || sym >= ALPHABET) begin
            push_reject();
            return;
        end
        slot = cursor * ALPHABET + sym;
        child = goto_tab[slot];
        if (child == 0) begin
            if (n_nodes >= NODES) begin
                push_reject();
                return;
            end
            child = n_nodes;
            goto_tab[slot] = child[7:0];
            n_nodes++;
        end
        if (cursor == 0) pat_len[n_pats] = 8'd1;
        else pat_len[n_pats] = pat_len[n_pats] + 8'd1;
        cursor = child;
        if (fin) begin
            hits_of[child][n_pats] = 1'b1;
            n_pats++;
            cursor = 0;
        end
    endtask

    // Breadth-first fail links, inherited match sets and completed goto function.
    task automatic build_automaton();
        int order [$];
        int u, v, f;
        if (is_built) return;
        for (int c = 0; c < ALPHABET; c++) begin
            v = goto_tab[c];
            if (v != 0) begin
                fail_of[v] = 8'd0;
                order.push_back(v);
            end
        end
        while (order.size() > 0) begin
            u = order.pop_front();
            f = fail_of[u];
            for (int c = 0; c < ALPHABET; c++) begin
                v = goto_tab[u*ALPHABET + c];
                if (v != 0) begin
                    fail_of[v] = goto_tab[f*ALPHABET + c];
                    hits_of[v] = hits_of[v] | hits_of[fail_of[v]];
                    order.push_back(v);
                end else begin
                    goto_tab[u*ALPHABET + c] = goto_tab[f*ALPHABET + c];
                end
            end
        end
        is_built = 1'b1;
        cursor = 0;
        scan_at = 0;
        text_pos = '0;
    endtask

    task automatic scan_letter(input int sym, input logic first);
        t_report r;
        logic [15:0] bits;
        int n;
        if (!is_built) return;
        if (first) begin
            scan_at = 0;
            text_pos = '0;
        end
        if (sym >= ALPHABET) begin
            scan_at = 0;
        end else begin
            scan_at = goto_tab[scan_at*ALPHABET + sym];
            bits = hits_of[scan_at];
            n = 0;
            for (int id = 0; id < PATS; id++) begin
                if (bits[id]) begin
                    r = '{status: 1'b0, id: id[3:0],
                          start: text_pos + 32'd1 - 32'(pat_len[id]), last: 1'b0};
                    expected_reports.push_back(r);
                    n++;
                end
            end
            if (n > 0) expected_reports[$].last = 1'b1;
        end
        text_pos = text_pos + 32'd1;
    endtask

    // Predict on each accepted input item; compare each accepted result.
    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (!i_rst_n) begin
            foreach (goto_tab[k]) goto_tab[k] = '0;
            foreach (fail_of[k]) fail_of[k] = '0;
            foreach (hits_of[k]) hits_of[k] = '0;
            n_nodes = 1;
            n_pats = 0;
            cursor = 0;
            is_built = 1'b0;
            scan_at = 0;
            text_pos = '0;
            expected_reports.delete();
            o_fail_count = 0;
            o_report_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{status: i_status, id: i_pattern_id, start: i_start_position,
                        last: i_last};
                o_report_count++;
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected", got, got);
                end else begin
                    want = expected_reports.pop_front();
                    if (got != want) report_mismatch("field", got, want);
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (t_func'(i_func))
                    FN_PAT:   add_letter(int'(i_symbol), i_last_of_pattern);
                    FN_BUILD: build_automaton();
                    FN_TEXT:  scan_letter(int'(i_symbol), i_first_of_text);
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- bench/tb_aho_corasick_matcher.sv -----
// Top of the matcher testbench: clock, reset, stimulus phases and verdict.
module tb_aho_corasick_matcher;
    import acm_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [1:0]       i_func;
    logic [SYM_W-1:0] i_symbol;
    logic             i_last_of_pattern;
    logic             i_first_of_text;
    logic             o_valid;
    logic             i_ready;
    logic             o_status;
    logic [3:0]       o_pattern_id;
    logic [31:0]      o_start_position;
    logic             o_last;
    int               fail_count;
    int               pending;
    int               report_count;
    int               cycle_count;
    int               items_sent;
    bit               calm_sink;

    aho_corasick_matcher dut (.*);

    acm_match_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_func(i_func), .i_symbol(i_symbol),
        .i_last_of_pattern(i_last_of_pattern), .i_first_of_text(i_first_of_text),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_status(o_status), .i_pattern_id(o_pattern_id),
        .i_start_position(o_start_position), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending), .o_report_count(report_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Cycle guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_aho_corasick_matcher NOT OK");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result-side backpressure, sometimes switched off for a stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n || calm_sink) i_ready <= 1'b1;
        else i_ready <= (gap_len() == 0);
    end

    // Drive one item; valid stays high after acceptance unless an idle gap follows.
    task automatic send_item(input t_func fn, input int sym, input bit fin, input bit first);
        int g;
        g = calm_sink ? 0 : gap_len();
        // Idle gap with valid low and a scrambled payload.
        if (g > 0) begin
            i_valid <= 1'b0;
            i_func <= 2'($urandom_range(0, 3));
            i_symbol <= SYM_W'($urandom_range(0, 31));
            i_last_of_pattern <= 1'($urandom_range(0, 1));
            i_first_of_text <= 1'($urandom_range(0, 1));
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_symbol <= sym[SYM_W-1:0];
        i_last_of_pattern <= fin;
        i_first_of_text <= first;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_word(input int word [$]);
        foreach (word[k]) send_item(FN_PAT, word[k], k == word.size() - 1, 1'b0);
    endtask

    // Full reset of the block between campaigns is not allowed; a fresh
    // dictionary therefore only exists at the start. Later campaigns reuse it.
    task automatic send_text(input int n, input int alpha);
        for (int k = 0; k < n; k++) begin
            int sym;
            sym = ($urandom_range(0, 29) == 0) ? $urandom_range(26, 31)
                                               : $urandom_range(0, alpha - 1);
            send_item(FN_TEXT, sym, $urandom_range(0, 1), (k == 0) || ($urandom_range(0, 40) == 0));
        end
    endtask

    initial begin
        int w [$];
        cycle_count = 0;
        items_sent = 0;
        calm_sink = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FN_NONE;
        i_symbol = '0;
        i_last_of_pattern = 1'b0;
        i_first_of_text = 1'b0;
        i_ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: text before build, unused code, bad letters, patterns with overlap.
        send_item(FN_TEXT, 0, 1'b0, 1'b1);
        send_item(FN_NONE, 31, 1'b1, 1'b1);
        send_item(FN_PAT, 31, 1'b1, 1'b0);
        send_item(FN_PAT, 0, 1'b0, 1'b1);
        send_item(FN_PAT, 26, 1'b0, 1'b0);
        w = '{0}; send_word(w);
        w = '{0, 0}; send_word(w);
        w = '{0}; send_word(w);
        w = '{25, 1}; send_word(w);
        w = '{1, 25, 1}; send_word(w);
        send_item(FN_PAT, 2, 1'b0, 1'b0);
        send_item(FN_PAT, 3, 1'b0, 1'b0);

        // Random dictionary: short words over a small alphabet, some over all letters.
        for (int p = 0; p < 14; p++) begin
            int len;
            len = $urandom_range(1, 5);
            w.delete();
            for (int k = 0; k < len; k++)
                w.push_back((p > 10) ? $urandom_range(0, 25) : $urandom_range(0, 3));
            send_word(w);
        end
        send_item(FN_BUILD, $urandom_range(0, 31), 1'b0, 1'b0);
        send_item(FN_BUILD, 0, 1'b1, 1'b1);
        send_item(FN_PAT, 0, 1'b1, 1'b0);

        // Directed scan over the overlapping words, then random text.
        send_item(FN_TEXT, 0, 1'b0, 1'b1);
        send_item(FN_TEXT, 0, 1'b0, 1'b0);
        send_item(FN_TEXT, 0, 1'b0, 1'b0);
        send_item(FN_TEXT, 1, 1'b0, 1'b0);
        send_item(FN_TEXT, 25, 1'b0, 1'b0);
        send_item(FN_TEXT, 1, 1'b0, 1'b0);
        send_item(FN_TEXT, 30, 1'b0, 1'b0);
        send_text(150, 4);
        calm_sink = 1'b1;
        send_text(60, 4);
        calm_sink = 1'b0;
        send_text(80, 26);
        for (int k = 0; k < 10; k++)
            send_item(t_func'($urandom_range(0, 3)), $urandom_range(0, 31),
                      $urandom_range(0, 1), $urandom_range(0, 1));
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("sent %0d items, checked %0d results over one dictionary and its scans",
                 items_sent, report_count);
        if (fail_count == 0 && pending == 0)
            $display("tb_aho_corasick_matcher OK");
        else
            $display("tb_aho_corasick_matcher NOT OK");
        $finish;
    end

endmodule
